>>> rtl/core/cvle_pkg.sv
// ----------------------------------------------------------------------------
// Calendar validate and local epoch package
// Shared types, calendar constants and date helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package cvle_pkg;

  localparam int unsigned YearMin     = 2025;
  localparam int unsigned YearMax     = 2040;
  localparam int unsigned EpochYear   = 1970;
  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned HoursPerDay = 24;
  localparam int unsigned MinsPerHour = 60;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned MonthsPerYear = 12;

  // Days from the epoch to the first of January of YearMin.
  localparam int unsigned DaysToYearMin = (YearMin - EpochYear) * 365 +
      ((YearMin - 1) / 4 - (YearMin - 1) / 100 + (YearMin - 1) / 400) -
      ((EpochYear - 1) / 4 - (EpochYear - 1) / 100 + (EpochYear - 1) / 400);

  localparam int unsigned InBytes  = 5;
  localparam int unsigned OutBytes = 8;

  // Packed with the first field in the highest bits.
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } reading_t;

  typedef struct packed {
    logic [31:0] unix_seconds;
    logic [4:0]  local_hour;
    logic [4:0]  local_day;
    logic [3:0]  local_month;
    logic [11:0] local_year;
  } out_data_t;

  typedef struct packed {
    logic      time_valid;
    out_data_t data;
  } result_t;

  // Leap test for the supported window (2024 to 2041 holds no century year).
  function automatic logic is_leap(logic [11:0] year);
    return (year[1:0] == 2'b00);
  endfunction

  function automatic logic [4:0] days_in(logic [11:0] year, logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:                    len = is_leap(year) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Days before the first of the given month in a common year.
  function automatic logic [8:0] month_start(logic [3:0] month);
    logic [8:0] days;
    case (month)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

  // Days from the epoch to the first of January of YearMin + offset.
  // The first leap year of the window is YearMin + 3.
  function automatic logic [14:0] year_start(logic [3:0] offset);
    return 15'(DaysToYearMin) + 15'(offset) * 15'd365 + 15'(offset >> 2);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/cvle_in_reg.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted calendar reading until the conversion stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cvle_in_reg
  import cvle_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire reading_t data_i,
  output logic          valid_o,
  input  wire logic     ready_i,
  output reading_t      data_o
);

  logic     valid_q;
  reading_t data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cvle_convert.sv
// ----------------------------------------------------------------------------
// Calendar conversion
// Validates a reading, shifts it to local time and forms the Unix time.
// ----------------------------------------------------------------------------
`default_nettype none

module cvle_convert
  import cvle_pkg::*;
(
  input  wire reading_t   reading_i,
  input  wire logic [4:0] tz_offset_hours_i,
  output result_t         result_o
);

  logic               valid;
  logic signed [6:0]  tz_ext;
  logic signed [6:0]  lh;
  logic signed [6:0]  hour_shift;
  logic [5:0]         ld;
  logic [3:0]         lm;
  logic [11:0]        ly;
  logic [11:0]        year_off;
  logic [14:0]        days;
  logic [31:0]        ts;

  always_comb begin
    valid = (reading_i.year >= 12'(YearMin)) && (reading_i.year <= 12'(YearMax)) &&
            (reading_i.month >= 4'd1) && (reading_i.month <= 4'(MonthsPerYear)) &&
            (reading_i.day >= 5'd1) &&
            (reading_i.hour < 5'(HoursPerDay)) &&
            (reading_i.minute < 6'(MinsPerHour)) &&
            (reading_i.second < 6'(SecsPerMin));

    tz_ext = $signed({{2{tz_offset_hours_i[4]}}, tz_offset_hours_i});
    lh     = $signed({2'b00, reading_i.hour}) + tz_ext;
    ld     = {1'b0, reading_i.day};
    lm     = reading_i.month;
    ly     = reading_i.year;

    if (lh >= 7'sd24) begin
      lh = lh - 7'sd24;
      ld = ld + 6'd1;
      if (ld > {1'b0, days_in(ly, lm)}) begin
        ld = 6'd1;
        lm = lm + 4'd1;
        if (lm > 4'(MonthsPerYear)) begin
          lm = 4'd1;
          ly = ly + 12'd1;
        end
      end
    end else if (lh < 7'sd0) begin
      lh = lh + 7'sd24;
      if (ld <= 6'd1) begin
        if (lm <= 4'd1) begin
          lm = 4'(MonthsPerYear);
          ly = ly - 12'd1;
        end else begin
          lm = lm - 4'd1;
        end
        ld = {1'b0, days_in(ly, lm)};
      end else begin
        ld = ld - 6'd1;
      end
    end

    year_off   = reading_i.year - 12'(YearMin);
    days       = year_start(year_off[3:0]) + 15'(month_start(reading_i.month)) +
                 15'((is_leap(reading_i.year) && (reading_i.month > 4'd2)) ? 1 : 0) +
                 15'(reading_i.day) - 15'd1;
    hour_shift = $signed({2'b00, reading_i.hour}) - tz_ext;
    ts         = 32'(days) * 32'(SecsPerDay) +
                 {{25{hour_shift[6]}}, hour_shift} * 32'(SecsPerHour) +
                 32'(reading_i.minute) * 32'(SecsPerMin) +
                 32'(reading_i.second);

    if (valid) begin
      result_o.time_valid        = 1'b1;
      result_o.data.local_year   = ly;
      result_o.data.local_month  = lm;
      result_o.data.local_day    = ld[4:0];
      result_o.data.local_hour   = lh[4:0];
      result_o.data.unix_seconds = ts;
    end else begin
      result_o.time_valid        = 1'b0;
      result_o.data.local_year   = reading_i.year;
      result_o.data.local_month  = reading_i.month;
      result_o.data.local_day    = reading_i.day;
      result_o.data.local_hour   = reading_i.hour;
      result_o.data.unix_seconds = 32'd0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cvle_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module cvle_out_reg
  import cvle_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  output logic         ready_o,
  input  wire result_t data_i,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      data_o
);

  logic    valid_q;
  result_t data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/calendar_validate_local_epoch_core.sv
// ----------------------------------------------------------------------------
// Calendar validate and local epoch core
// An input transfer passes the input register, the conversion and the result register to the output.
// Throughput is one reading per cycle while the output is ready, set by the input and result registers.
// Reset clears both stage valid flags and sets the timezone offset to zero.
// The configuration channel is always ready and takes one write per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_validate_local_epoch_core
  import cvle_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [4:0]              cfg_data_i,    // tz_offset_hours
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // year, month, day, hour, minute, second, zero fill
  input  wire logic [InBytes*8-1:0]    s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // local_year, local_month, local_day, local_hour, unix_seconds, zero fill
  output logic [OutBytes*8-1:0]        m_axis_tdata,
  output logic                         m_axis_tuser   // time_valid
);

  logic [4:0] tz_offset_hours_q;
  reading_t   in_reading;
  reading_t   stage_reading;
  logic       stage_valid;
  logic       stage_ready;
  result_t    conv_result;
  result_t    out_result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tz_offset_hours_q <= 5'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tz_offset_hours_q <= cfg_data_i;
    end
  end

  assign in_reading = s_axis_tdata[$bits(reading_t)-1:0];

  cvle_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (in_reading),
    .valid_o (stage_valid),
    .ready_i (stage_ready),
    .data_o  (stage_reading)
  );

  cvle_convert u_convert (
    .reading_i         (stage_reading),
    .tz_offset_hours_i (tz_offset_hours_q),
    .result_o          (conv_result)
  );

  cvle_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid),
    .ready_o (stage_ready),
    .data_i  (conv_result),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_result)
  );

  assign m_axis_tdata  = {{(OutBytes*8-$bits(out_data_t)){1'b0}}, out_result.data};
  assign m_axis_tuser  = out_result.time_valid;

endmodule

`default_nettype wire
